// File: rtl/core/cqa_pkg.sv
// cqa_pkg: shared types and constants for the congestion scored queue assigner
// used by cqa_div, cqa_ctrl, cqa_dp and the top level; depends on nothing

package cqa_pkg;

	localparam int FLOW_W   = 32;
	localparam int KEY_W    = 2 * FLOW_W;
	localparam int TIME_W   = 48;
	localparam int OCC_W    = 16;
	localparam int WEIGHT_W = 16;
	localparam int TREND_W  = 32;
	localparam int DIV_W    = 48;
	localparam int PROD_W   = 48;
	localparam int SCORE_W  = PROD_W + 1;
	localparam int CFG_W    = 16;

	// nanoseconds per second, minimum spacing of trend updates, default capacity
	localparam logic [29:0]       NS_PER_S         = 30'd1000000000;
	localparam logic [TIME_W-1:0] MIN_TREND_DT     = 48'd1000;
	localparam logic [OCC_W-1:0]  DEFAULT_CAPACITY = 16'd1000;

	localparam logic ACT_ASSIGN = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	typedef enum logic [1:0] {
		REG_OCC_WEIGHT     = 2'd0,
		REG_TREND_WEIGHT   = 2'd1,
		REG_QUEUE_CAPACITY = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_KNOWN  = 2'd0,
		KIND_UNUSED = 2'd1,
		KIND_SCORED = 2'd2
	} assign_kind_t;

	// operand selection for the shared divider
	typedef enum logic [1:0] {
		DIV_TREND  = 2'd0,
		DIV_OCC    = 2'd1,
		DIV_SPREAD = 2'd2
	} div_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     take;
		logic     trend_init;
		logic     trend_mul;
		logic     trend_write;
		logic     trend_stamp;
		logic     qidx_clr;
		logic     qidx_inc;
		logic     eidx_inc;
		logic     div_start;
		div_sel_t div_sel;
		logic     mm_step;
		logic     prod_occ;
		logic     acc_load;
		logic     prod_trn;
		logic     best_upd;
		logic     res_known;
		logic     res_free;
		logic     res_score;
		logic     record;
		logic     out_load;
	} cqa_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic started;
		logic dt_ok;
		logic qidx_last;
		logic scan_end;
		logic hit;
		logic any_free;
		logic div_busy;
	} cqa_stat_t;

endpackage

// File: rtl/core/cqa_ram.sv
// cqa_ram: generic single write port, single read port memory with registered read
// no dependencies

module cqa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/cqa_div.sv
// cqa_div: restoring divider, one quotient bit per cycle
// depends on cqa_pkg for the operand width

module cqa_div
	import cqa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             busy,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/cqa_ctrl.sv
// cqa_ctrl: sequencing state machine for trend update, table scan, scoring and output
// depends on cqa_pkg for the command and status structs

module cqa_ctrl
	import cqa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      action,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output cqa_cmd_t  cmd,
	input  cqa_stat_t stat
);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_TCHK   = 16'h0002,
		S_TMUL   = 16'h0004,
		S_TSTART = 16'h0008,
		S_TDIV   = 16'h0010,
		S_LREAD  = 16'h0020,
		S_LCMP   = 16'h0040,
		S_PICK   = 16'h0080,
		S_MINMAX = 16'h0100,
		S_SSTART = 16'h0200,
		S_SOCC   = 16'h0400,
		S_STRN   = 16'h0800,
		S_SADD   = 16'h1000,
		S_SSEL   = 16'h2000,
		S_RECORD = 16'h4000,
		S_OUT    = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (action == ACT_ASSIGN) begin
						state_d = S_TCHK;
					end
				end
			end
			S_TCHK: begin
				if (!stat.started) begin
					cmd.trend_init = 1'b1;
					state_d        = S_LREAD;
				end else if (stat.dt_ok) begin
					state_d = S_TMUL;
				end else begin
					state_d = S_LREAD;
				end
			end
			S_TMUL: begin
				cmd.trend_mul = 1'b1;
				state_d       = S_TSTART;
			end
			S_TSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_TREND;
				state_d       = S_TDIV;
			end
			S_TDIV: begin
				if (!stat.div_busy) begin
					cmd.trend_write = 1'b1;
					if (stat.qidx_last) begin
						cmd.trend_stamp = 1'b1;
						cmd.qidx_clr    = 1'b1;
						state_d         = S_LREAD;
					end else begin
						cmd.qidx_inc = 1'b1;
						state_d      = S_TMUL;
					end
				end
			end
			S_LREAD: begin
				state_d = stat.scan_end ? S_PICK : S_LCMP;
			end
			S_LCMP: begin
				if (stat.hit) begin
					cmd.res_known = 1'b1;
					state_d       = S_OUT;
				end else begin
					cmd.eidx_inc = 1'b1;
					state_d      = S_LREAD;
				end
			end
			S_PICK: begin
				if (stat.any_free) begin
					cmd.res_free = 1'b1;
					state_d      = S_RECORD;
				end else begin
					state_d = S_MINMAX;
				end
			end
			S_MINMAX: begin
				cmd.mm_step = 1'b1;
				if (stat.qidx_last) begin
					cmd.qidx_clr = 1'b1;
					state_d      = S_SSTART;
				end else begin
					cmd.qidx_inc = 1'b1;
				end
			end
			S_SSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_OCC;
				state_d       = S_SOCC;
			end
			S_SOCC: begin
				if (!stat.div_busy) begin
					cmd.prod_occ  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SPREAD;
					state_d       = S_STRN;
				end
			end
			S_STRN: begin
				cmd.acc_load = 1'b1;
				if (!stat.div_busy) begin
					cmd.prod_trn = 1'b1;
					state_d      = S_SADD;
				end
			end
			S_SADD: begin
				cmd.best_upd = 1'b1;
				if (stat.qidx_last) begin
					state_d = S_SSEL;
				end else begin
					cmd.qidx_inc = 1'b1;
					state_d      = S_SSTART;
				end
			end
			S_SSEL: begin
				cmd.res_score = 1'b1;
				state_d       = S_RECORD;
			end
			S_RECORD: begin
				cmd.record = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a result never overwrites one still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending one");

	// a recorded assign request moves straight on to the output state
	a_assign_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RECORD) |=> (state_q == S_OUT))
		else $error("recorded message did not reach output");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule

// File: rtl/core/cqa_dp.sv
// cqa_dp: message table, queue state, trend and score arithmetic, output register
// depends on cqa_pkg, cqa_ram and cqa_div

module cqa_dp
	import cqa_pkg::*;
#(
	parameter int NUM_QUEUES   = 8,
	parameter int MAX_MESSAGES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              action,
	input  logic [FLOW_W-1:0] source_flow,
	input  logic [FLOW_W-1:0] dest_flow,
	input  logic [2:0]        report_queue,
	input  logic [OCC_W-1:0]  report_occupancy,
	input  logic [TIME_W-1:0] now_ns,
	output logic [2:0]        assigned_queue,
	output logic [1:0]        assign_kind,
	output logic              table_full,
	input  cqa_cmd_t          cmd,
	output cqa_stat_t         stat
);

	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int AW  = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
	localparam int CW  = $clog2(MAX_MESSAGES + 1);
	localparam int EW  = KEY_W + QW;

	// configuration
	logic [WEIGHT_W-1:0] occ_weight_q;
	logic [WEIGHT_W-1:0] trend_weight_q;
	logic [OCC_W-1:0]    capacity_q;

	// queue state
	logic [OCC_W-1:0]          occ_q   [NUM_QUEUES];
	logic [OCC_W-1:0]          prev_q  [NUM_QUEUES];
	logic signed [TREND_W-1:0] trend_q [NUM_QUEUES];
	logic [NUM_QUEUES-1:0]     in_use_q;
	logic [TIME_W-1:0]         last_q;
	logic                      started_q;

	// item and scan state
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     eidx_q;
	logic [QW-1:0]     qidx_q;

	// arithmetic
	logic [PROD_W-1:0]         prod_q;
	logic [PROD_W-1:0]         acc_q;
	logic                      neg_q;
	logic [SCORE_W-1:0]        best_q;
	logic [QW-1:0]             bestq_q;
	logic signed [TREND_W-1:0] mn_q;
	logic signed [TREND_W-1:0] mx_q;

	// result and output registers
	logic [QW-1:0]     res_queue_q;
	assign_kind_t      res_kind_q;
	logic              res_full_q;
	logic [2:0]        out_queue_q;
	assign_kind_t      out_kind_q;
	logic              out_full_q;

	// combinational helpers
	logic [TIME_W-1:0]         dt;
	logic [OCC_W-1:0]          cur_occ;
	logic [OCC_W-1:0]          cur_prev;
	logic signed [TREND_W-1:0] cur_trend;
	logic [OCC_W-1:0]          mag;
	logic [TREND_W:0]          spread_num;
	logic [TREND_W:0]          spread;
	logic [TREND_W-1:0]        range_sel;
	logic [OCC_W-1:0]          cap_sel;
	logic [DIV_W-1:0]          div_dvd;
	logic [DIV_W-1:0]          div_dvs;
	logic [DIV_W-1:0]          div_quo;
	logic                      div_busy;
	logic [WEIGHT_W-1:0]       mul_a;
	logic [PROD_W-1:0]         mul_out;
	logic [SCORE_W-1:0]        score;
	logic [TREND_W-1:0]        trend_sat;
	logic [QW-1:0]             free_idx;
	logic                      any_free;
	logic                      room;
	logic                      report_hit;
	logic                      ram_we;
	logic [EW-1:0]             ram_rdata;

	// per-queue operand selection
	always_comb begin
		cur_occ   = occ_q[qidx_q];
		cur_prev  = prev_q[qidx_q];
		cur_trend = trend_q[qidx_q];
		dt        = now_q - last_q;
		mag       = (cur_occ >= cur_prev) ? (cur_occ - cur_prev) : (cur_prev - cur_occ);
		spread_num = {cur_trend[TREND_W-1], cur_trend} - {mn_q[TREND_W-1], mn_q};
		spread     = {mx_q[TREND_W-1], mx_q} - {mn_q[TREND_W-1], mn_q};
		range_sel  = (spread[TREND_W-1:0] == '0) ? TREND_W'(1) : spread[TREND_W-1:0];
		cap_sel    = (capacity_q == '0) ? DEFAULT_CAPACITY : capacity_q;
	end

	// divider operand mux
	always_comb begin
		case (cmd.div_sel)
			DIV_OCC: begin
				div_dvd = {16'b0, cur_occ, 16'b0};
				div_dvs = DIV_W'(cap_sel);
			end
			DIV_SPREAD: begin
				div_dvd = {spread_num[TREND_W-1:0], 16'b0};
				div_dvs = DIV_W'(range_sel);
			end
			default: begin
				div_dvd = prod_q;
				div_dvs = dt;
			end
		endcase
	end

	cqa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// shared weight multiplier and score sum
	always_comb begin
		mul_a   = cmd.prod_trn ? trend_weight_q : occ_weight_q;
		mul_out = PROD_W'(mul_a) * PROD_W'(div_quo[31:0]);
		score   = {1'b0, acc_q} + {1'b0, prod_q};
	end

	// trend rate saturation to the signed 32-bit range
	always_comb begin
		if (neg_q) begin
			trend_sat = (div_quo > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000
				: (32'd0 - div_quo[31:0]);
		end else begin
			trend_sat = (div_quo > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
				: div_quo[31:0];
		end
	end

	// lowest unused queue
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = QW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign room       = count_q < CW'(MAX_MESSAGES);
	assign ram_we     = cmd.record && room;
	assign report_hit = cmd.take && (action == ACT_REPORT)
		&& ({29'b0, report_queue} < 32'(NUM_QUEUES));

	// message table: key over recorded queue
	cqa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_MESSAGES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({key_q, res_queue_q}),
		.raddr (eidx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_weight_q   <= 16'd4096;
			trend_weight_q <= 16'd4096;
			capacity_q     <= DEFAULT_CAPACITY;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_OCC_WEIGHT:     occ_weight_q   <= cfg_data;
				REG_TREND_WEIGHT:   trend_weight_q <= cfg_data;
				REG_QUEUE_CAPACITY: capacity_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// queue state, table fill and indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				occ_q[i]   <= '0;
				prev_q[i]  <= '0;
				trend_q[i] <= '0;
			end
			in_use_q  <= '0;
			last_q    <= '0;
			started_q <= 1'b0;
			count_q   <= '0;
			eidx_q    <= '0;
			qidx_q    <= '0;
			mn_q      <= '0;
			mx_q      <= '0;
		end else begin
			if (report_hit) begin
				occ_q[QW'(report_queue)] <= report_occupancy;
			end
			if (cmd.take) begin
				eidx_q <= '0;
				qidx_q <= '0;
				mn_q   <= '0;
				mx_q   <= '0;
			end
			if (cmd.trend_init) begin
				for (int i = 0; i < NUM_QUEUES; i++) begin
					prev_q[i]  <= '0;
					trend_q[i] <= '0;
				end
				started_q <= 1'b1;
				last_q    <= now_q;
			end
			if (cmd.trend_write) begin
				trend_q[qidx_q] <= trend_sat;
				prev_q[qidx_q]  <= cur_occ;
			end
			if (cmd.trend_stamp) begin
				last_q <= now_q;
			end
			if (cmd.qidx_clr) begin
				qidx_q <= '0;
			end else if (cmd.qidx_inc) begin
				qidx_q <= qidx_q + 1'b1;
			end
			if (cmd.eidx_inc) begin
				eidx_q <= eidx_q + 1'b1;
			end
			if (cmd.mm_step) begin
				if (cur_trend < mn_q) begin
					mn_q <= cur_trend;
				end
				if (cur_trend > mx_q) begin
					mx_q <= cur_trend;
				end
			end
			if (ram_we) begin
				count_q               <= count_q + 1'b1;
				in_use_q[res_queue_q] <= 1'b1;
			end
		end
	end

	// item latch, arithmetic and result registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			key_q <= {source_flow, dest_flow};
			now_q <= now_ns;
		end
		if (cmd.trend_mul) begin
			prod_q <= PROD_W'(mag) * PROD_W'(NS_PER_S);
			neg_q  <= cur_occ < cur_prev;
		end else if (cmd.prod_occ || cmd.prod_trn) begin
			prod_q <= mul_out;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end
		if (cmd.best_upd && ((qidx_q == '0) || (score < best_q))) begin
			best_q  <= score;
			bestq_q <= qidx_q;
		end
		if (cmd.res_known) begin
			res_queue_q <= ram_rdata[QW-1:0];
			res_kind_q  <= KIND_KNOWN;
			res_full_q  <= 1'b0;
		end else if (cmd.res_free) begin
			res_queue_q <= free_idx;
			res_kind_q  <= KIND_UNUSED;
		end else if (cmd.res_score) begin
			res_queue_q <= bestq_q;
			res_kind_q  <= KIND_SCORED;
		end
		if (cmd.record) begin
			res_full_q <= !room;
		end
		if (cmd.out_load) begin
			out_queue_q <= 3'(res_queue_q);
			out_kind_q  <= res_kind_q;
			out_full_q  <= res_full_q;
		end
	end

	// status back to the controller
	always_comb begin
		stat.started   = started_q;
		stat.dt_ok     = (now_q > last_q) && (dt > MIN_TREND_DT);
		stat.qidx_last = (qidx_q == QW'(NUM_QUEUES - 1));
		stat.scan_end  = (eidx_q == count_q);
		stat.hit       = (ram_rdata[EW-1:QW] == key_q);
		stat.any_free  = any_free;
		stat.div_busy  = div_busy;
	end

	assign assigned_queue = out_queue_q;
	assign assign_kind    = out_kind_q;
	assign table_full     = out_full_q;

	// fill count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_MESSAGES))
		else $error("message count beyond table depth");

	// the divider is never restarted mid-division
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");

	// a record into a table with room grows the fill count by one
	a_record_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.record && room) |=> (count_q == $past(count_q) + 1'b1))
		else $error("record did not advance fill count");

endmodule

// File: rtl/core/congestion_scored_queue_assigner.sv
// congestion_scored_queue_assigner: top level, maps messages to output queues
// depends on cqa_pkg, cqa_ctrl and cqa_dp
//
//  channel   signals                                        direction
//  input     in_valid, in_stall, action .. now_ns            item in
//  output    out_valid, out_stall, assigned_queue .. full    item out
//  config    cfg_wr_en, cfg_index, cfg_data                  write only
//
// an occupancy report is applied as it is taken; an assign request refreshes
// the trends when more than 1 us passed since the last trend update, scans the
// table entry by entry, scores every queue when every queue is in use and
// records a new message; all divisions share one divider, and no new item
// is taken until the result has gone to the output register
// reset is asynchronous and clears all queue state and the table fill count
// a finished result waits in the output register while the next item is taken

module congestion_scored_queue_assigner
	import cqa_pkg::*;
#(
	parameter int NUM_QUEUES   = 8,
	parameter int MAX_MESSAGES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [FLOW_W-1:0] source_flow,
	input  logic [FLOW_W-1:0] dest_flow,
	input  logic [2:0]        report_queue,
	input  logic [OCC_W-1:0]  report_occupancy,
	input  logic [TIME_W-1:0] now_ns,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        assigned_queue,
	output logic [1:0]        assign_kind,
	output logic              table_full
);

	cqa_cmd_t  cmd;
	cqa_stat_t stat;

	cqa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	cqa_dp #(
		.NUM_QUEUES   (NUM_QUEUES),
		.MAX_MESSAGES (MAX_MESSAGES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.action           (action),
		.source_flow      (source_flow),
		.dest_flow        (dest_flow),
		.report_queue     (report_queue),
		.report_occupancy (report_occupancy),
		.now_ns           (now_ns),
		.assigned_queue   (assigned_queue),
		.assign_kind      (assign_kind),
		.table_full       (table_full),
		.cmd              (cmd),
		.stat             (stat)
	);

endmodule

// File: bench/tb_congestion_scored_queue_assigner.sv
// tb_congestion_scored_queue_assigner: self-checking bench for the queue assigner
// drives assign requests and occupancy reports, predicts each assignment in-line
// depends on cqa_pkg and congestion_scored_queue_assigner

module tb_congestion_scored_queue_assigner;
	import cqa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUES   = 8;
	localparam int MESSAGES = 256;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic [2:0]   queue;
		assign_kind_t kind;
		logic         full;
	} assignment_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = ACT_ASSIGN;
	logic [FLOW_W-1:0] source_flow = '0;
	logic [FLOW_W-1:0] dest_flow = '0;
	logic [2:0]        report_queue = '0;
	logic [OCC_W-1:0]  report_occupancy = '0;
	logic [TIME_W-1:0] now_ns = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        assigned_queue;
	logic [1:0]        assign_kind;
	logic              table_full;

	// predictor state
	logic [KEY_W-1:0]  msg_key [MESSAGES];
	logic [2:0]        msg_queue [MESSAGES];
	bit                msg_valid [MESSAGES];
	int                msg_count;
	bit                queue_used [QUEUES];
	logic [OCC_W-1:0]  occupancy [QUEUES];
	logic [OCC_W-1:0]  prev_occupancy [QUEUES];
	int                trend [QUEUES];
	logic [TIME_W-1:0] trend_stamp;
	bit                trend_live;
	logic [15:0]       occ_weight;
	logic [15:0]       trn_weight;
	logic [15:0]       capacity;

	assignment_t       expected_assignments [$];
	logic [KEY_W-1:0]  known_keys [$];
	logic [TIME_W-1:0] clock_ns;
	int                errors = 0;
	int                rx_hold = 0;
	bit                idle_enable = 1'b1;

	congestion_scored_queue_assigner u_dut (.*);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_enable || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		static int run_left = 0;
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold = rx_hold - 1;
		end else if (run_left > 0) begin
			run_left = run_left - 1;
		end else begin
			run_left = pick_gap();
			out_stall <= (run_left > 0) && $urandom_range(0, 1);
		end
	end

	// result checker
	always @(posedge clk) begin
		assignment_t exp_a;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_assignments.size() == 0) begin
				$error("unexpected result: queue %0d kind %0d full %0d",
					assigned_queue, assign_kind, table_full);
				errors++;
			end else begin
				exp_a = expected_assignments.pop_front();
				if (assigned_queue !== exp_a.queue) begin
					$error("assigned_queue: expected %0d, got %0d", exp_a.queue, assigned_queue);
					errors++;
				end
				if (assign_kind !== exp_a.kind) begin
					$error("assign_kind: expected %0d, got %0d", exp_a.kind, assign_kind);
					errors++;
				end
				if (table_full !== exp_a.full) begin
					$error("table_full: expected %0d, got %0d", exp_a.full, table_full);
					errors++;
				end
			end
		end
	end

	// trend refresh at the start of an assign request
	function automatic void refresh_trend(logic [TIME_W-1:0] now);
		longint dt, delta, mag;
		if (!trend_live) begin
			trend_live = 1'b1;
			foreach (trend[i]) begin
				trend[i] = 0;
				prev_occupancy[i] = '0;
			end
			trend_stamp = now;
			return;
		end
		if (now <= trend_stamp) return;
		dt = longint'(now - trend_stamp);
		if (dt <= 1000) return;
		for (int i = 0; i < QUEUES; i++) begin
			delta = longint'(occupancy[i]) - longint'(prev_occupancy[i]);
			mag = (delta < 0 ? -delta : delta) * 64'd1000000000 / dt;
			if (delta < 0) trend[i] = (mag > 64'd2147483648) ? 32'sh80000000 : int'(-mag);
			else trend[i] = (mag > 64'd2147483647) ? 32'sh7fffffff : int'(mag);
			prev_occupancy[i] = occupancy[i];
		end
		trend_stamp = now;
	endfunction

	// lowest congestion score, lower queue on a tie
	function automatic logic [2:0] lowest_score_queue();
		longint mn, mx, spread, cap, no, nt, s, best;
		logic [2:0] best_q;
		mn = 0;
		mx = 0;
		best = 0;
		best_q = '0;
		cap = (capacity != 0) ? longint'(capacity) : 1000;
		foreach (trend[i]) begin
			if (trend[i] < mn) mn = trend[i];
			if (trend[i] > mx) mx = trend[i];
		end
		spread = (mx - mn == 0) ? 1 : mx - mn;
		for (int i = 0; i < QUEUES; i++) begin
			no = (longint'(occupancy[i]) << 16) / cap;
			nt = ((longint'(trend[i]) - mn) << 16) / spread;
			s = longint'(occ_weight) * no + longint'(trn_weight) * nt;
			if (i == 0 || s < best) begin
				best = s;
				best_q = i[2:0];
			end
		end
		return best_q;
	endfunction

	// expected assignment for one accepted request, updating the table
	function automatic assignment_t predict_assignment(logic [KEY_W-1:0] key,
			logic [TIME_W-1:0] now);
		assignment_t a;
		int slot;
		slot = -1;
		refresh_trend(now);
		for (int i = 0; i < MESSAGES; i++)
			if (msg_valid[i] && msg_key[i] == key) begin
				a.queue = msg_queue[i];
				a.kind = KIND_KNOWN;
				a.full = 1'b0;
				return a;
			end
		a.kind = KIND_SCORED;
		for (int i = QUEUES - 1; i >= 0; i--)
			if (!queue_used[i]) begin
				a.queue = i[2:0];
				a.kind = KIND_UNUSED;
			end
		if (a.kind == KIND_SCORED) a.queue = lowest_score_queue();
		for (int i = MESSAGES - 1; i >= 0; i--)
			if (!msg_valid[i]) slot = i;
		a.full = (slot < 0);
		if (slot >= 0) begin
			msg_valid[slot] = 1'b1;
			msg_key[slot] = key;
			msg_queue[slot] = a.queue;
			queue_used[a.queue] = 1'b1;
			msg_count++;
			known_keys.push_back(key);
		end
		return a;
	endfunction

	// send one item, entered and left at a falling edge
	task automatic send_item(logic act, logic [KEY_W-1:0] key, logic [2:0] rq,
			logic [OCC_W-1:0] ro, logic [TIME_W-1:0] ns);
		int gap;
		in_valid <= 1'b1;
		action <= act;
		source_flow <= key[63:32];
		dest_flow <= key[31:0];
		report_queue <= rq;
		report_occupancy <= ro;
		now_ns <= ns;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (act == ACT_REPORT) occupancy[rq] = ro;
		else expected_assignments.push_back(predict_assignment(key, ns));
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [TIME_W-1:0] advance_clock();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) clock_ns += TIME_W'($urandom_range(0, 1000));
		else if (r < 70) clock_ns += TIME_W'($urandom_range(1001, 20000));
		else if (r < 85) clock_ns += TIME_W'($urandom_range(1, 1000000)) * 48'd1000;
		else if (r < 93) clock_ns -= TIME_W'($urandom_range(1, 5000));
		else clock_ns = TIME_W'({$urandom, $urandom});
		return clock_ns;
	endfunction

	function automatic logic [OCC_W-1:0] pick_occupancy();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		if (r < 6) return OCC_W'($urandom_range(0, 1200));
		return OCC_W'($urandom);
	endfunction

	task automatic send_report(logic [2:0] q, logic [OCC_W-1:0] occ);
		send_item(ACT_REPORT, {$urandom, $urandom}, q, occ, TIME_W'({$urandom, $urandom}));
	endtask

	task automatic send_assign(logic [KEY_W-1:0] key, logic [TIME_W-1:0] ns);
		send_item(ACT_ASSIGN, key, 3'($urandom), OCC_W'($urandom), ns);
	endtask

	// one random item: report, known message or new message
	task automatic send_random(int new_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) send_report(3'($urandom), pick_occupancy());
		else if (r < 100 - new_pct && known_keys.size() > 0)
			send_assign(known_keys[$urandom_range(0, known_keys.size() - 1)], advance_clock());
		else send_assign({$urandom, $urandom}, advance_clock());
	endtask

	// drop valid and wait until the block has drained
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_assignments.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	// one register write, after which the write port idles before the task returns
	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_OCC_WEIGHT:     occ_weight = value;
			REG_TREND_WEIGHT:   trn_weight = value;
			REG_QUEUE_CAPACITY: capacity = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// extremes, every kind of assignment, trend corner cases
	task automatic test_directed();
		idle_enable = 1'b0;
		send_report(3'd0, 16'd0);
		send_report(3'd7, 16'hffff);
		send_assign(64'h0000_0001_0000_0002, 48'd100);
		send_assign(64'h0000_0001_0000_0002, 48'd50);
		send_assign(64'hffff_ffff_ffff_ffff, 48'd600);
		for (int i = 0; i < QUEUES; i++) send_report(i[2:0], 16'(i * 300));
		send_assign(64'h0, 48'd5000);
		send_assign(64'h8000_0000_0000_0001, 48'd10000);
		send_assign(64'h1234_5678_9abc_def0, 48'd20000);
		send_assign(64'h0fed_cba9_8765_4321, 48'd30000);
		send_assign(64'h5555_aaaa_5555_aaaa, 48'd40000);
		send_assign(64'haaaa_5555_aaaa_5555, 48'd50000);
		send_report(3'd2, 16'hffff);
		send_report(3'd5, 16'd0);
		send_assign(64'h0000_0000_ffff_ffff, 48'd51001);
		send_assign(64'hffff_ffff_0000_0000, 48'hffff_ffff_ffff);
		send_assign(64'h0000_0001_0000_0002, 48'd0);
		idle_enable = 1'b1;
		wait_drained();
	endtask

	// random traffic under several register settings
	task automatic test_register_sweep();
		logic [15:0] settings [5][3] = '{
			'{16'd4096, 16'd4096, 16'd1000},
			'{16'd0, 16'hffff, 16'd0},
			'{16'hffff, 16'd0, 16'd1},
			'{16'hffff, 16'hffff, 16'hffff},
			'{16'd2048, 16'd12288, 16'd200}};
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_OCC_WEIGHT, settings[p][0]);
			write_reg(REG_TREND_WEIGHT, settings[p][1]);
			write_reg(REG_QUEUE_CAPACITY, settings[p][2]);
			write_reg(REG_SPARE, CFG_W'($urandom));
			for (int n = 0; n < 40; n++) send_random(35);
			wait_drained();
		end
	endtask

	// long receiver hold-off while items keep coming
	task automatic test_backpressure();
		rx_hold = 4000;
		for (int n = 0; n < 20; n++) send_random(30);
		wait_drained();
	endtask

	// overflow the message table
	task automatic test_table_fill();
		while (msg_count < MESSAGES) send_random(85);
		for (int n = 0; n < 30; n++) send_random(60);
		wait_drained();
	endtask

	initial begin
		msg_count = 0;
		occ_weight = 16'd4096;
		trn_weight = 16'd4096;
		capacity = 16'd1000;
		trend_stamp = '0;
		trend_live = 1'b0;
		clock_ns = 48'd100000;
		foreach (msg_valid[i]) msg_valid[i] = 1'b0;
		foreach (occupancy[i]) begin
			queue_used[i] = 1'b0;
			occupancy[i] = '0;
			prev_occupancy[i] = '0;
			trend[i] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_register_sweep();
		test_backpressure();
		test_table_fill();
		repeat (2000) @(posedge clk);
		if (errors == 0 && expected_assignments.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
